// ----- sv/nls_pkg.sv -----
// Shared types, constants and state encoding for the Nxx length statistic block.
package nls_pkg;

    localparam int unsigned MAX_ITEMS_DEF   = 1024;
    localparam int unsigned LENGTH_BITS_DEF = 32;
    localparam int unsigned FRAC_W          = 17;
    localparam int unsigned FRAC_SHIFT      = 16;
    localparam logic [FRAC_W-1:0] FRAC_RESET = 17'd32768;

    typedef struct packed {
        logic [31:0] length;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] nxx_value;
        logic        found;
        logic        overflow;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_RD,
        ST_SORT_WAIT,
        ST_SORT_CMP,
        ST_SCAN_RD,
        ST_SCAN_WAIT,
        ST_SCAN_MUL,
        ST_SCAN_CMP,
        ST_OUT
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;        // store incoming length, add to total
        logic drop;        // mark overflow
        logic sort_init;   // i = 1, j = 1, take value at i
        logic sort_rd;     // read entry j-1 (or i at start of pass)
        logic sort_shift;  // write store[j] = store[j-1], j--
        logic sort_place;  // write store[j] = v, i++
        logic sort_fetch;  // capture v from read data
        logic scan_init;
        logic scan_rd;
        logic scan_acc;    // add read data to partial, capture candidate
        logic scan_next;
        logic finish;      // latch result
        logic clear;       // drop set state after result
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic full;        // storage holds MAX_ITEMS entries
        logic sort_done;   // i >= count
        logic j_zero;
        logic less;        // store[j-1] < v
        logic scan_done;   // idx >= count
        logic exceeds;
        logic fetch_phase; // next read is for v
    } status_t;

endpackage

// ----- sv/nls_ram.sv -----
// Generic single-port RAM with registered read data.
module nls_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- sv/nls_datapath.sv -----
// Datapath: length store, totals, insertion sort indexes and exact threshold compare.
module nls_datapath #(
    parameter int unsigned MAX_ITEMS   = nls_pkg::MAX_ITEMS_DEF,
    parameter int unsigned LENGTH_BITS = nls_pkg::LENGTH_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  nls_pkg::cmd_t                     cmd,
    input  logic [LENGTH_BITS-1:0]            in_len,
    input  logic [nls_pkg::FRAC_W-1:0]        fraction,
    output nls_pkg::status_t                  status,
    output nls_pkg::out_item_t                result
);
    import nls_pkg::*;

    localparam int unsigned AW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int unsigned CW  = $clog2(MAX_ITEMS + 1);
    localparam int unsigned TW  = LENGTH_BITS + CW;
    localparam int unsigned PW  = TW + FRAC_W;
    localparam int unsigned HW  = (TW + 1) / 2;

    logic [CW-1:0]          count_reg, count_next;
    logic [TW-1:0]          total_reg, total_next;
    logic                   ovf_reg, ovf_next;
    logic [CW-1:0]          i_reg, i_next;
    logic [CW-1:0]          j_reg, j_next;
    logic [LENGTH_BITS-1:0] v_reg, v_next;
    logic [TW-1:0]          partial_reg, partial_next;
    logic [LENGTH_BITS-1:0] cand_reg, cand_next;
    logic [PW-1:0]          prod_lo_reg, prod_hi_reg;
    logic [PW-1:0]          lhs_reg;
    logic                   fetch_reg, fetch_next;
    out_item_t              res_reg, res_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_addr;
    logic [LENGTH_BITS-1:0] ram_wdata, ram_rdata;
    logic [CW-1:0]          addr_full;
    logic [TW-1:0]          partial_sum;
    logic [PW-1:0]          threshold;

    nls_ram #(.WIDTH(LENGTH_BITS), .DEPTH(1 << AW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign partial_sum = partial_reg + TW'(ram_rdata);
    // fraction * total split into two half-width multiplies, summed next cycle
    assign threshold   = prod_lo_reg + (prod_hi_reg << HW);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = in_len;
        addr_full = count_reg;
        priority if (cmd.load)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.sort_rd)
        begin
            addr_full = fetch_reg ? i_reg : j_reg - CW'(1);
        end
        else if (cmd.sort_shift)
        begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            addr_full = j_reg;
        end
        else if (cmd.sort_place)
        begin
            ram_we    = 1'b1;
            ram_wdata = v_reg;
            addr_full = j_reg;
        end
        else if (cmd.scan_rd)
        begin
            addr_full = i_reg;
        end
        else
        begin
            addr_full = i_reg;
        end
        ram_addr = addr_full[AW-1:0];
    end

    always_comb
    begin
        count_next   = count_reg;
        total_next   = total_reg;
        ovf_next     = ovf_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        v_next       = v_reg;
        partial_next = partial_reg;
        cand_next    = cand_reg;
        fetch_next   = fetch_reg;
        res_next     = res_reg;
        if (cmd.load)
        begin
            count_next = count_reg + CW'(1);
            total_next = total_reg + TW'(in_len);
        end
        if (cmd.drop)
        begin
            ovf_next = 1'b1;
        end
        if (cmd.sort_init)
        begin
            i_next     = CW'(1);
            j_next     = CW'(1);
            fetch_next = 1'b1;
        end
        if (cmd.sort_fetch)
        begin
            v_next     = ram_rdata;
            fetch_next = 1'b0;
        end
        if (cmd.sort_shift)
        begin
            j_next = j_reg - CW'(1);
        end
        if (cmd.sort_place)
        begin
            i_next     = i_reg + CW'(1);
            j_next     = i_reg + CW'(1);
            fetch_next = 1'b1;
        end
        if (cmd.scan_init)
        begin
            i_next       = '0;
            partial_next = '0;
        end
        if (cmd.scan_acc)
        begin
            partial_next = partial_sum;
            cand_next    = ram_rdata;
        end
        if (cmd.scan_next)
        begin
            i_next = i_reg + CW'(1);
        end
        if (cmd.finish)
        begin
            res_next.nxx_value = status.exceeds ? 32'(cand_reg) : 32'd0;
            res_next.found     = status.exceeds;
            res_next.overflow  = ovf_reg;
        end
        if (cmd.clear)
        begin
            count_next = '0;
            total_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
            ovf_reg   <= 1'b0;
            fetch_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            total_reg <= total_next;
            ovf_reg   <= ovf_next;
            fetch_reg <= fetch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        v_reg       <= v_next;
        partial_reg <= partial_next;
        cand_reg    <= cand_next;
        res_reg     <= res_next;
        prod_lo_reg <= PW'(total_reg[HW-1:0]) * PW'(fraction);
        prod_hi_reg <= PW'(total_reg[TW-1:HW]) * PW'(fraction);
        lhs_reg     <= PW'(partial_reg) << FRAC_SHIFT;
    end

    assign status.full        = (count_reg == CW'(MAX_ITEMS));
    assign status.sort_done   = (i_reg >= count_reg);
    assign status.j_zero      = (j_reg == '0);
    assign status.less        = (ram_rdata < v_reg);
    assign status.scan_done   = (i_reg >= count_reg);
    assign status.exceeds     = (lhs_reg > threshold);
    assign status.fetch_phase = fetch_reg;
    assign result             = res_reg;
endmodule

// ----- sv/nls_ctrl.sv -----
// Controller: load, insertion sort and scan sequencing plus the channel handshakes.
module nls_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_last,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             cfg_ready,
    input  nls_pkg::status_t status,
    output nls_pkg::cmd_t    cmd
);
    import nls_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        cfg_ready  = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_stall  = 1'b0;
                cfg_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = !status.full;
                    cmd.drop = status.full;
                    if (in_last)
                    begin
                        cmd.sort_init = 1'b1;
                        state_next    = ST_SORT_RD;
                    end
                end
            end
            ST_SORT_RD:
            begin
                if (status.fetch_phase && status.sort_done)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
                else if (!status.fetch_phase && status.j_zero)
                begin
                    cmd.sort_place = 1'b1;
                end
                else
                begin
                    cmd.sort_rd = 1'b1;
                    state_next  = ST_SORT_WAIT;
                end
            end
            ST_SORT_WAIT:
            begin
                // hold the read address so the compare sees the same entry
                cmd.sort_rd = 1'b1;
                state_next  = ST_SORT_CMP;
            end
            ST_SORT_CMP:
            begin
                state_next = ST_SORT_RD;
                if (status.fetch_phase)
                begin
                    cmd.sort_fetch = 1'b1;
                end
                else if (status.less)
                begin
                    cmd.sort_shift = 1'b1;
                end
                else
                begin
                    cmd.sort_place = 1'b1;
                end
            end
            ST_SCAN_RD:
            begin
                if (status.scan_done)
                begin
                    // no crossing: report zero
                    state_next = ST_SCAN_MUL;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = ST_SCAN_WAIT;
                end
            end
            ST_SCAN_WAIT:
            begin
                cmd.scan_acc = !status.scan_done;
                state_next   = ST_SCAN_MUL;
            end
            ST_SCAN_MUL:
            begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                if (status.exceeds || status.scan_done)
                begin
                    cmd.finish = 1'b1;
                    cmd.clear  = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end
endmodule

// ----- sv/nxx_length_statistic.sv -----
// Top level of the Nxx length statistic block.
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/stall   | in_item_t  (length, last)
//  out     | output    | out_valid/stall  | out_item_t (nxx_value, found, overflow)
//  cfg     | input     | cfg_valid/ready  | fraction_q16
// Lengths load one per cycle while in_stall is low. After the last one, an
// insertion sort runs through the single RAM port, then the scan reads entries
// in order up to the crossing. One result then waits until taken.
// Reset clears counts and totals; the store needs no clearing.
module nxx_length_statistic #(
    parameter int unsigned MAX_ITEMS   = nls_pkg::MAX_ITEMS_DEF,
    parameter int unsigned LENGTH_BITS = nls_pkg::LENGTH_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  nls_pkg::in_item_t          in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output nls_pkg::out_item_t         out_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [nls_pkg::FRAC_W-1:0] cfg_data
);
    import nls_pkg::*;

    cmd_t                   cmd;
    status_t                status;
    logic [FRAC_W-1:0]      frac_reg;
    logic [LENGTH_BITS-1:0] len_masked;

    assign len_masked = LENGTH_BITS'(in_data.length);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg <= FRAC_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            frac_reg <= cfg_data;
        end
    end

    nls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (in_data.last),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    nls_datapath #(.MAX_ITEMS(MAX_ITEMS), .LENGTH_BITS(LENGTH_BITS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_len   (len_masked),
        .fraction (frac_reg),
        .status   (status),
        .result   (out_data)
    );

    // nothing is stored while full
    a_no_store_full: assert property (@(posedge clk) disable iff (!rst_n)
        status.full |-> !cmd.load) else $error("store written while full");

    // a result shows only after a finish
    a_out_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.finish)) else $error("result without finish");

    // input closed while sorting or scanning
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sort_rd || cmd.scan_rd) |-> in_stall) else $error("input open while busy");
endmodule
